### rtl/lkv_pkg.sv
// shared constants, types and helpers of the lru key-value cache
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [31:0]      MISS_VALUE = '1;
  localparam logic [31:0]      SET_VALUE  = '0;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;
    logic load;
    logic set_valid;
  } cell_ctrl_t;

  // hit information handed up the row
  typedef struct packed {
    logic                  seen;
    logic [VALUE_BITS-1:0] value;
  } cell_link_t;

  function automatic logic [KEY_BITS-1:0] to_key(input logic [31:0] x);
    logic signed [63:0] w;
    w = 64'(signed'(x));
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] to_value(input logic [31:0] x);
    logic signed [63:0] w;
    w = 64'(signed'(x));
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic logic [31:0] from_value(input logic [VALUE_BITS-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

endpackage

### rtl/lkv_cell.sv
// one cache cell: key, value and valid bit, with compare and neighbor shift
module lkv_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lkv_pkg::KEY_BITS-1:0]  lookup_key,
  input  lkv_pkg::cell_ctrl_t           ctrl,
  input  logic [lkv_pkg::KEY_BITS-1:0]  load_key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] load_value,
  input  logic [lkv_pkg::KEY_BITS-1:0]  nbr_key,
  input  logic [lkv_pkg::VALUE_BITS-1:0] nbr_value,
  input  lkv_pkg::cell_link_t           link_in,
  output lkv_pkg::cell_link_t           link_out,
  output logic [lkv_pkg::KEY_BITS-1:0]  stored_key,
  output logic [lkv_pkg::VALUE_BITS-1:0] stored_value,
  output logic                          valid,
  output logic                          seen
);
  import lkv_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  valid_r;
  logic                  match;

  assign match = valid_r && (key_r == lookup_key);
  assign link_out.seen  = link_in.seen | match;
  assign link_out.value = link_in.value | (match ? value_r : '0);
  assign seen  = link_out.seen;
  assign valid = valid_r;
  assign stored_key   = key_r;
  assign stored_value = value_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r   <= load_key;
      value_r <= load_value;
    end else if (ctrl.shift) begin
      key_r   <= nbr_key;
      value_r <= nbr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.set_valid) begin
      valid_r <= 1'b1;
    end
  end

endmodule

### rtl/lru_key_value_cache_unit.sv
// top level of the lru key-value cache: cell row, fill count and result register
//
// fully associative key-value store with least-recently-used replacement,
// built as a row of cells kept packed in recency order (cell 0 least recent).
// every transfer compares its key with all cells at once; a hit shifts the
// younger cells down one place and reloads the entry at the most recent end,
// a set of a new key appends it there, dropping cell 0 first when the fill
// has reached the capacity register. an item is finished in the cycle it is
// accepted and its result waits in an output register, so one item per cycle
// goes through as long as the result side does not stall; the path is the
// key compare and the hit-prefix chain up the row. capacity 0 acts as 1, and
// values above the number of cells act as the number of cells.
module lru_key_value_cache_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_lookup_key,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  import lkv_pkg::*;

  // configuration and fill state
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] used_r, used_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r;
  logic [31:0] out_read_value_r;

  // row wiring
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]    cell_valid;
  logic [ENTRIES-1:0]    cell_seen;
  cell_link_t            link [ENTRIES+1];
  cell_ctrl_t            ctrl [ENTRIES];

  logic                  accept;
  logic                  hit;
  logic                  set_miss;
  logic                  evict;
  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] entry_value;
  logic [CMP_W-1:0]      cap_eff;
  logic [CMP_W-1:0]      used_cmp;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign key_in = to_key(in_lookup_key);
  assign link[0] = '0;
  assign hit = link[ENTRIES].seen;

  // clamp the capacity register to the row
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign used_cmp = CMP_W'(used_r);
  assign set_miss = accept && (in_kind == KIND_SET) && !hit;
  // full at the capacity: drop the oldest cell before the append
  assign evict    = set_miss && (used_cmp >= cap_eff) && (used_r != '0);

  // a set hit rewrites the value, a get hit carries the stored one up
  assign entry_value = (in_kind == KIND_SET) ? to_value(in_write_value) : link[ENTRIES].value;

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
      localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);

      logic top_cell;   // cell used-1, the most recent one
      logic next_free;  // cell used, first empty one

      assign top_cell  = (IDX1 == used_r);
      assign next_free = (IDX == used_r);

      always_comb begin
        ctrl[i].shift     = accept && ((hit && cell_seen[i] && !top_cell) ||
                                       (evict && (IDX1 < used_r)));
        ctrl[i].load      = accept && ((hit && top_cell) || (evict && top_cell) ||
                                       (set_miss && !evict && next_free));
        ctrl[i].set_valid = set_miss && !evict && next_free;
      end

      if (i < ENTRIES - 1) begin : g_nbr
        lkv_cell u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .lookup_key   (key_in),
          .ctrl         (ctrl[i]),
          .load_key     (key_in),
          .load_value   (entry_value),
          .nbr_key      (cell_key[i+1]),
          .nbr_value    (cell_value[i+1]),
          .link_in      (link[i]),
          .link_out     (link[i+1]),
          .stored_key   (cell_key[i]),
          .stored_value (cell_value[i]),
          .valid        (cell_valid[i]),
          .seen         (cell_seen[i])
        );
      end else begin : g_last
        // the last cell has no upper neighbor: its neighbor input is itself, so a shift keeps its contents
        lkv_cell u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .lookup_key   (key_in),
          .ctrl         (ctrl[i]),
          .load_key     (key_in),
          .load_value   (entry_value),
          .nbr_key      (cell_key[i]),
          .nbr_value    (cell_value[i]),
          .link_in      (link[i]),
          .link_out     (link[i+1]),
          .stored_key   (cell_key[i]),
          .stored_value (cell_value[i]),
          .valid        (cell_valid[i]),
          .seen         (cell_seen[i])
        );
      end
    end
  endgenerate

  // fill count grows only on an append without eviction
  always_comb begin
    used_nxt = used_r;
    if (set_miss && !evict && (used_r < CNT_W'(ENTRIES))) begin
      used_nxt = used_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on every transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r <= hit;
      if (in_kind == KIND_SET) begin
        out_read_value_r <= SET_VALUE;
      end else if (hit) begin
        out_read_value_r <= from_value(link[ENTRIES].value);
      end else begin
        out_read_value_r <= MISS_VALUE;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

`ifndef SYNTHESIS
  // fill count stays inside the row
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond the row");

  // the number of valid cells equals the fill count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(used_r))
    else $error("valid bits disagree with fill count");

  // an accepted transfer always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transfer without result");

  // a finished result is held while the result side stalls
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_read_value_r)))
    else $error("stalled result changed");
`endif

endmodule
